[rtl/core/cftlp_pkg.sv]
`timescale 1ns / 1ps

package cftlp_pkg;

    localparam int CHAR_W              = 8;
    localparam int NIB_W               = 4;
    localparam int BYTE_W              = 8;
    localparam int NUM_BYTES           = 8;
    localparam int DEF_MAX_DATA_BYTES  = 8;
    localparam int COUNT_W             = 4;
    localparam int SEC_W               = 63;
    localparam int TS_W                = 64;
    localparam int ID_W                = 32;
    localparam int QUEUE_DEPTH         = 4;

    // Output packing, lowest bit first.
    localparam int TS_LSB     = 0;
    localparam int ID_LSB     = TS_LSB + TS_W;
    localparam int CNT_LSB    = ID_LSB + ID_W;
    localparam int BYTES_LSB  = CNT_LSB + COUNT_W;
    localparam int PAYLOAD_W  = BYTES_LSB + NUM_BYTES * BYTE_W;
    localparam int TDATA_W    = ((PAYLOAD_W + 7) / 8) * 8;
    localparam int PAD_W      = TDATA_W - PAYLOAD_W;

    // Decimal accumulators saturate at the signed 64-bit maximum.
    localparam logic [SEC_W-1:0] DEC_MAX     = '1;
    localparam logic [SEC_W-1:0] DEC_LIM     = DEC_MAX / 10;
    localparam logic [NIB_W-1:0] DEC_REM     = NIB_W'(DEC_MAX % 10);
    localparam logic [TS_W-1:0]  US_PER_SEC  = 64'd1000000;
    localparam logic [TS_W-1:0]  PROD_SAT    = TS_W'({1'b0, DEC_MAX} * US_PER_SEC);

    localparam logic [ID_W-1:0]  ID_MAX      = '1;
    localparam logic [ID_W-1:0]  ID_LIM      = ID_MAX / 16;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_F   = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_F   = 8'h66;
    localparam logic [NIB_W-1:0]  HEX_ALPHA_OFS = 4'd9;

    typedef struct packed {
        logic             last;
        logic             nul;
        logic             space;
        logic             tab;
        logic             lparen;
        logic             rparen;
        logic             dot;
        logic             hash;
        logic             digit;
        logic             hex;
        logic [NIB_W-1:0] nib;
    } t_token;

    typedef enum logic [8:0] {
        PH_LEAD  = 9'b000000001,
        PH_SEC   = 9'b000000010,
        PH_USEC  = 9'b000000100,
        PH_SP1   = 9'b000001000,
        PH_IFACE = 9'b000010000,
        PH_SP2   = 9'b000100000,
        PH_IDENT = 9'b001000000,
        PH_DATA  = 9'b010000000,
        PH_HALT  = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic                               frame_ok;
        logic [TS_W-1:0]                    sec_us;
        logic [SEC_W-1:0]                   micros;
        logic [ID_W-1:0]                    ident;
        logic [COUNT_W-1:0]                 count;
        logic [NUM_BYTES-1:0][BYTE_W-1:0]   bytes;
    } t_snap;

    function automatic logic dec_sat(input logic [SEC_W-1:0] acc, input logic [NIB_W-1:0] d);
        return (acc > DEC_LIM) || ((acc == DEC_LIM) && (d > DEC_REM));
    endfunction

    function automatic logic [SEC_W-1:0] dec_push(input logic [SEC_W-1:0] acc,
                                                  input logic [NIB_W-1:0] d);
        if (dec_sat(acc, d)) begin
            return DEC_MAX;
        end
        return (acc << 3) + (acc << 1) + SEC_W'(d);
    endfunction

    // Running seconds * 1e6, kept in step with the seconds accumulator.
    function automatic logic [TS_W-1:0] prod_push(input logic [TS_W-1:0] prod,
                                                  input logic sat,
                                                  input logic [NIB_W-1:0] d);
        if (sat) begin
            return PROD_SAT;
        end
        return (prod << 3) + (prod << 1) + (TS_W'(d) * US_PER_SEC);
    endfunction

endpackage

[rtl/core/can_frame_text_line_parser.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// -------   ---  ---------------------  ------------------------------------------------
// s (char)  in   i_s_tvalid/o_s_tready  i_s_tdata: character; i_s_tlast: line_end
// m (frame) out  o_m_tvalid/i_m_tready  o_m_tuser: frame_ok; o_m_tdata: see port comment
//
// Takes one character per clock while the queue has room, lines back to back
// with no gap at line end. A result passes through the snapshot register, then
// the output register with the timestamp add; the parser handles one queued
// character per cycle unless a line end waits on a stalled result path.
// Reset is synchronous, active low; it empties the queue and result stages.
// A stalled output holds the result; the four-entry queue keeps accepting until full.

module can_frame_text_line_parser
    import cftlp_pkg::*;
#(
    parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [CHAR_W-1:0]  i_s_tdata,   // [7:0] character
    input  logic               i_s_tlast,   // line_end
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // [63:0] stamp_us, [95:64] identifier, [99:96] byte_count,
    // [107:100] data_byte0 ... [163:156] data_byte7, [167:164] zero
    output logic [TDATA_W-1:0] o_m_tdata,
    output logic               o_m_tuser    // [0] frame_ok
);

    t_token w_in_token;
    t_token w_q_token;
    logic   w_push;
    logic   w_q_valid;
    logic   w_pop;
    logic   w_snap_valid;
    logic   w_snap_ready;
    t_snap  w_snap;

    // Front: classify each character as it arrives
    cftlp_front u_front (
        .i_char  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_token (w_in_token)
    );

    assign w_push = i_s_tvalid && o_s_tready;

    // Short queue decouples intake from the parser
    cftlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_in_token),
        .o_ready (o_s_tready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_token (w_q_token)
    );

    // Back: phase machine and accumulators; hands a snapshot over at line end
    cftlp_parse #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_token      (w_q_token),
        .o_pop        (w_pop),
        .o_snap_valid (w_snap_valid),
        .o_snap       (w_snap),
        .i_snap_ready (w_snap_ready)
    );

    // Finish: add microseconds to the scaled seconds, hold the result for the sink
    cftlp_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (w_snap_valid),
        .i_snap       (w_snap),
        .o_snap_ready (w_snap_ready),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

    // A line end waiting on a full result path must not be dropped
    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_snap_valid && !w_snap_ready) |=> w_snap_valid)
        else $error("line end token lost while result path stalled");

    // A good frame always carries at least one byte
    a_ok_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[CNT_LSB +: COUNT_W] != '0))
        else $error("frame_ok with zero byte count");

    // Byte count stays within the configured limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[CNT_LSB +: COUNT_W] <= COUNT_W'(MAX_DATA_BYTES)))
        else $error("byte count exceeds limit");

endmodule

[rtl/core/cftlp_front.sv]
`timescale 1ns / 1ps

module cftlp_front
    import cftlp_pkg::*;
(
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_last,
    output t_token            o_token
);

    logic w_digit;
    logic w_lc_hex;
    logic w_uc_hex;

    assign w_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign w_lc_hex = (i_char >= CH_LC_A) && (i_char <= CH_LC_F);
    assign w_uc_hex = (i_char >= CH_UC_A) && (i_char <= CH_UC_F);

    always_comb begin
        o_token        = '0;
        o_token.last   = i_last;
        o_token.nul    = (i_char == CH_NUL);
        o_token.space  = (i_char == CH_SPACE);
        o_token.tab    = (i_char == CH_TAB);
        o_token.lparen = (i_char == CH_LPAREN);
        o_token.rparen = (i_char == CH_RPAREN);
        o_token.dot    = (i_char == CH_DOT);
        o_token.hash   = (i_char == CH_HASH);
        o_token.digit  = w_digit;
        o_token.hex    = w_digit || w_lc_hex || w_uc_hex;
        // letters a-f / A-F: low nibble 1..6 maps to 10..15
        o_token.nib    = w_digit ? i_char[NIB_W-1:0]
                                 : NIB_W'(i_char[NIB_W-1:0] + HEX_ALPHA_OFS);
    end

endmodule

[rtl/core/cftlp_queue.sv]
`timescale 1ns / 1ps

module cftlp_queue
    import cftlp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    output logic   o_ready,
    input  logic   i_pop,
    output logic   o_valid,
    output t_token o_token
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_token             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= CNT_W'(r_count + 1'b1);
                2'b01:   r_count <= CNT_W'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/cftlp_parse.sv]
`timescale 1ns / 1ps

module cftlp_parse
    import cftlp_pkg::*;
#(
    parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_token i_token,
    output logic   o_pop,
    output logic   o_snap_valid,
    output t_snap  o_snap,
    input  logic   i_snap_ready
);

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DATA_BYTES);

    t_phase             r_phase,  n_phase;
    logic [SEC_W-1:0]   r_sec,    n_sec;
    logic [TS_W-1:0]    r_prod,   n_prod;
    logic [SEC_W-1:0]   r_usec,   n_usec;
    logic [ID_W-1:0]    r_ident,  n_ident;
    logic [COUNT_W-1:0] r_count,  n_count;
    logic               r_nib_ok, n_nib_ok;
    logic [NIB_W-1:0]   r_nib,    n_nib;
    logic               r_hash,   n_hash;
    logic [BYTE_W-1:0]  r_store [MAX_DATA_BYTES];
    logic [BYTE_W-1:0]  n_store [MAX_DATA_BYTES];

    logic                             put_en;
    logic [BYTE_W-1:0]                put_val;
    logic                             do_ident;
    logic                             sec_sat;
    logic [COUNT_W-1:0]               cnt_inc;
    logic [NUM_BYTES-1:0][BYTE_W-1:0] w_bytes;

    assign o_pop        = i_valid && (!i_token.last || i_snap_ready);
    assign o_snap_valid = i_valid && i_token.last;
    assign cnt_inc      = COUNT_W'(r_count + 1'b1);
    assign sec_sat      = dec_sat(r_sec, i_token.nib);

    always_comb begin
        n_phase  = r_phase;
        n_sec    = r_sec;
        n_prod   = r_prod;
        n_usec   = r_usec;
        n_ident  = r_ident;
        n_count  = r_count;
        n_nib_ok = r_nib_ok;
        n_nib    = r_nib;
        n_hash   = r_hash;
        n_store  = r_store;
        put_en   = 1'b0;
        put_val  = '0;
        do_ident = 1'b0;

        if (i_token.nul) begin
            // NUL ends the line early; a pending digit still forms a byte
            if ((r_phase == PH_DATA) && r_nib_ok) begin
                put_en  = 1'b1;
                put_val = {{(BYTE_W-NIB_W){1'b0}}, r_nib};
            end
            n_nib_ok = 1'b0;
            n_phase  = PH_HALT;
        end else begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (i_token.lparen) begin
                        n_phase = PH_SEC;
                    end else if (!i_token.space && !i_token.tab) begin
                        n_phase = PH_IFACE;
                    end
                end
                PH_SEC: begin
                    if (i_token.digit) begin
                        n_sec  = dec_push(r_sec, i_token.nib);
                        n_prod = prod_push(r_prod, sec_sat, i_token.nib);
                    end else if (i_token.dot) begin
                        n_phase = PH_USEC;
                    end else if (i_token.rparen || i_token.space) begin
                        n_phase = PH_SP1;
                    end else begin
                        n_phase = PH_IFACE;
                    end
                end
                PH_USEC: begin
                    if (i_token.digit) begin
                        n_usec = dec_push(r_usec, i_token.nib);
                    end else if (i_token.rparen || i_token.space) begin
                        n_phase = PH_SP1;
                    end else begin
                        n_phase = PH_IFACE;
                    end
                end
                PH_SP1: begin
                    if (!i_token.space) begin
                        n_phase = PH_IFACE;
                    end
                end
                PH_IFACE: begin
                    if (i_token.space) begin
                        n_phase = PH_SP2;
                    end
                end
                PH_SP2: begin
                    do_ident = !i_token.space;
                end
                PH_IDENT: begin
                    do_ident = 1'b1;
                end
                PH_DATA: begin
                    if (r_nib_ok) begin
                        // second digit completes the pair; a non-hex char closes a lone digit
                        put_en   = 1'b1;
                        put_val  = i_token.hex ? {r_nib, i_token.nib}
                                               : {{(BYTE_W-NIB_W){1'b0}}, r_nib};
                        n_nib_ok = 1'b0;
                        if (cnt_inc >= MAX_CNT) begin
                            n_phase = PH_HALT;
                        end
                    end else if ((r_count >= MAX_CNT) || !i_token.hex) begin
                        n_phase = PH_HALT;
                    end else begin
                        n_nib_ok = 1'b1;
                        n_nib    = i_token.nib;
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_ident) begin
            if (i_token.hex) begin
                n_phase = PH_IDENT;
                n_ident = (r_ident > ID_LIM) ? ID_MAX
                                             : {r_ident[ID_W-NIB_W-1:0], i_token.nib};
            end else if (i_token.hash) begin
                n_hash  = 1'b1;
                n_phase = PH_DATA;
            end else begin
                n_phase = PH_HALT;
            end
        end

        // end of line: a digit left pending forms a byte by itself
        if (i_token.last && (n_phase == PH_DATA) && n_nib_ok) begin
            put_en   = 1'b1;
            put_val  = {{(BYTE_W-NIB_W){1'b0}}, n_nib};
            n_nib_ok = 1'b0;
        end

        if (put_en && (r_count < MAX_CNT)) begin
            for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                if (r_count == COUNT_W'(i)) begin
                    n_store[i] = put_val;
                end
            end
            n_count = cnt_inc;
        end
    end

    for (genvar g = 0; g < NUM_BYTES; g++) begin : g_bytes
        if (g < MAX_DATA_BYTES) begin : g_used
            assign w_bytes[g] = n_store[g];
        end else begin : g_unused
            assign w_bytes[g] = '0;
        end
    end

    always_comb begin
        o_snap          = '0;
        o_snap.frame_ok = n_hash && (n_count != '0);
        o_snap.sec_us   = n_prod;
        o_snap.micros   = n_usec;
        o_snap.ident    = n_hash ? n_ident : '0;
        o_snap.count    = n_count;
        o_snap.bytes    = w_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_token.last)) begin
            r_phase  <= PH_LEAD;
            r_sec    <= '0;
            r_prod   <= '0;
            r_usec   <= '0;
            r_ident  <= '0;
            r_count  <= '0;
            r_nib_ok <= 1'b0;
            r_nib    <= '0;
            r_hash   <= 1'b0;
            for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                r_store[i] <= '0;
            end
        end else if (o_pop) begin
            r_phase  <= n_phase;
            r_sec    <= n_sec;
            r_prod   <= n_prod;
            r_usec   <= n_usec;
            r_ident  <= n_ident;
            r_count  <= n_count;
            r_nib_ok <= n_nib_ok;
            r_nib    <= n_nib;
            r_hash   <= n_hash;
            r_store  <= n_store;
        end
    end

endmodule

[rtl/core/cftlp_emit.sv]
`timescale 1ns / 1ps

module cftlp_emit
    import cftlp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_snap_valid,
    input  t_snap              i_snap,
    output logic               o_snap_ready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,
    output logic               o_m_tuser
);

    logic               r_snap_valid;
    t_snap              r_snap;
    logic               r_out_valid;
    logic [TDATA_W-1:0] r_tdata;
    logic               r_tuser;
    logic               out_free;
    logic [TS_W-1:0]    w_ts;

    assign out_free     = !r_out_valid || i_m_tready;
    assign o_snap_ready = !r_snap_valid || out_free;
    assign w_ts         = r_snap.sec_us + TS_W'(r_snap.micros);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_snap_ready) begin
                r_snap_valid <= i_snap_valid;
            end
            if (out_free) begin
                r_out_valid <= r_snap_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap_valid && o_snap_ready) begin
            r_snap <= i_snap;
        end
        if (r_snap_valid && out_free) begin
            r_tdata <= {{PAD_W{1'b0}}, r_snap.bytes, r_snap.count, r_snap.ident, w_ts};
            r_tuser <= r_snap.frame_ok;
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import cftlp_pkg::*;

    localparam int          CYCLE_LIMIT = 500000;
    localparam int          RAND_ITEMS  = 650;
    localparam int          MIN_LINES   = 15;
    localparam int          DRAIN_WAIT  = 8;
    localparam int          HOLD_CYCLES = 300;
    localparam byte unsigned NUL_MARK   = 8'h7E;  // tilde in a table row stands for NUL
    localparam byte unsigned CH_CR      = 8'h0D;
    localparam byte unsigned CH_LF      = 8'h0A;
    localparam logic [63:0] SEC_SAT     = {1'b0, DEC_MAX};
    localparam logic [63:0] ID_SAT      = 64'hFFFF_FFFF;

    typedef struct packed {
        logic                   ok;
        logic [TS_W-1:0]        ts;
        logic [ID_W-1:0]        id;
        logic [COUNT_W-1:0]     cnt;
        logic [7:0][BYTE_W-1:0] bytes;
    } t_frame;

    typedef struct {
        string  txt;
        bit     typed;
        t_frame want;
    } t_line_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [CHAR_W-1:0]  i_s_tdata = '0;
    logic               i_s_tlast = 1'b0;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_tdata;
    logic               o_m_tuser;

    can_frame_text_line_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Line parser model state.
    t_phase                 ph;
    logic [63:0]            sec_acc;
    logic [63:0]            usec_acc;
    logic [63:0]            id_acc;
    logic [7:0][BYTE_W-1:0] byte_buf;
    int                     nbytes;
    bit                     nib_ok;
    logic [3:0]             nib;
    bit                     hash_seen;

    t_frame      expected_frames[$];
    t_line_row   line_rows[$];
    byte unsigned line_chars[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;        // neither side idles while set, bar the hold-off
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    bit          typed_on = 1'b0;
    t_frame      typed_frame;

    function automatic int hex_value(input byte unsigned c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
        return -1;
    endfunction

    function automatic logic [63:0] push_decimal(input logic [63:0] acc, input int d);
        if (acc > (SEC_SAT - 64'(d)) / 10) return SEC_SAT;
        return acc * 10 + 64'(d);
    endfunction

    function automatic void clear_parser();
        ph        = PH_LEAD;
        sec_acc   = '0;
        usec_acc  = '0;
        id_acc    = '0;
        byte_buf  = '0;
        nbytes    = 0;
        nib_ok    = 1'b0;
        nib       = '0;
        hash_seen = 1'b0;
    endfunction

    function automatic void store_byte(input logic [7:0] v);
        if (nbytes < DEF_MAX_DATA_BYTES) begin
            byte_buf[nbytes] = v;
            nbytes++;
        end
    endfunction

    // A pending high nibble becomes a byte of its own.
    function automatic void flush_nibble();
        if (ph == PH_DATA && nib_ok) store_byte({4'h0, nib});
        nib_ok = 1'b0;
        nib    = '0;
    endfunction

    function automatic void parse_char(input byte unsigned c);
        bit again;
        int d;
        if (c == CH_NUL) begin
            flush_nibble();
            ph = PH_HALT;
            return;
        end
        d     = hex_value(c);
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (ph)
                PH_LEAD: begin
                    if (c == CH_LPAREN) ph = PH_SEC;
                    else if (c != CH_SPACE && c != CH_TAB) begin
                        ph    = PH_SP1;
                        again = 1'b1;
                    end
                end
                PH_SEC: begin
                    if (c >= CH_ZERO && c <= CH_NINE) sec_acc = push_decimal(sec_acc, d);
                    else if (c == CH_DOT) ph = PH_USEC;
                    else if (c == CH_RPAREN) ph = PH_SP1;
                    else begin
                        ph    = PH_SP1;
                        again = 1'b1;
                    end
                end
                PH_USEC: begin
                    if (c >= CH_ZERO && c <= CH_NINE) usec_acc = push_decimal(usec_acc, d);
                    else begin
                        ph    = PH_SP1;
                        again = (c != CH_RPAREN);
                    end
                end
                PH_SP1: begin
                    if (c != CH_SPACE) ph = PH_IFACE;
                end
                PH_IFACE: begin
                    if (c == CH_SPACE) ph = PH_SP2;
                end
                PH_SP2: begin
                    if (c != CH_SPACE) begin
                        ph    = PH_IDENT;
                        again = 1'b1;
                    end
                end
                PH_IDENT: begin
                    if (d >= 0) begin
                        if (id_acc > (ID_SAT - 64'(d)) / 16) id_acc = ID_SAT;
                        else id_acc = id_acc * 16 + 64'(d);
                    end else if (c == CH_HASH) begin
                        hash_seen = 1'b1;
                        ph        = PH_DATA;
                    end else begin
                        ph = PH_HALT;
                    end
                end
                PH_DATA: begin
                    if (nib_ok) begin
                        // second digit completes the pair; anything else is eaten
                        if (d >= 0) store_byte({nib, 4'(d)});
                        else store_byte({4'h0, nib});
                        nib_ok = 1'b0;
                        if (nbytes >= DEF_MAX_DATA_BYTES) ph = PH_HALT;
                    end else if (nbytes >= DEF_MAX_DATA_BYTES || d < 0) begin
                        ph = PH_HALT;
                    end else begin
                        nib_ok = 1'b1;
                        nib    = 4'(d);
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic t_frame close_line();
        t_frame f;
        flush_nibble();
        f.ok    = hash_seen && nbytes > 0;
        f.ts    = sec_acc * 64'd1000000 + usec_acc;
        f.id    = hash_seen ? id_acc[ID_W-1:0] : '0;
        f.cnt   = 4'(nbytes);
        f.bytes = byte_buf;
        clear_parser();
        return f;
    endfunction

    function automatic void add_row(input string txt, input bit typed, input logic ok,
                                    input logic [63:0] ts, input logic [31:0] id,
                                    input logic [3:0] cnt, input logic [63:0] bytes);
        t_line_row r;
        r.txt   = txt;
        r.typed = typed;
        r.want  = '{ok: ok, ts: ts, id: id, cnt: cnt, bytes: bytes};
        line_rows.push_back(r);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic byte unsigned rand_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10) return 8'(CH_ZERO + v);
        return 8'(($urandom_range(1) ? CH_UC_A : CH_LC_A) + v - 10);
    endfunction

    function automatic void push_decimal_run();
        int n;
        n = ($urandom_range(9) < 8) ? $urandom_range(1, 10) : $urandom_range(18, 22);
        repeat (n) line_chars.push_back(8'(CH_ZERO + $urandom_range(9)));
    endfunction

    // Build one random line: mostly well formed with random content, some noise.
    function automatic void make_line();
        int n;
        line_chars.delete();
        if ($urandom_range(99) < 12) begin
            n = $urandom_range(1, 12);
            repeat (n) line_chars.push_back(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(0, 2)) line_chars.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
        if ($urandom_range(9) < 8) begin
            line_chars.push_back(CH_LPAREN);
            push_decimal_run();
            if ($urandom_range(9) < 8) begin
                line_chars.push_back(CH_DOT);
                push_decimal_run();
            end
            if ($urandom_range(9) < 9) line_chars.push_back(CH_RPAREN);
        end
        repeat ($urandom_range(1, 2)) line_chars.push_back(CH_SPACE);
        repeat ($urandom_range(1, 4)) line_chars.push_back(8'(CH_LC_A + $urandom_range(25)));
        line_chars.push_back(8'(CH_ZERO + $urandom_range(9)));
        repeat ($urandom_range(1, 2)) line_chars.push_back(CH_SPACE);
        n = ($urandom_range(9) < 9) ? $urandom_range(1, 8) : $urandom_range(9, 11);
        repeat (n) line_chars.push_back(rand_hex_char());
        if ($urandom_range(99) < 92) line_chars.push_back(CH_HASH);
        repeat ($urandom_range(0, 18)) line_chars.push_back(rand_hex_char());
        n = $urandom_range(99);
        if (n < 10) begin
            line_chars.push_back($urandom_range(1) ? CH_CR : CH_LF);
            if ($urandom_range(1)) line_chars.push_back(CH_LF);
        end else if (n < 16) begin
            line_chars.push_back(CH_NUL);
            repeat ($urandom_range(0, 3)) line_chars.push_back(rand_hex_char());
        end
        if ($urandom_range(9) == 0)
            line_chars[$urandom_range(line_chars.size() - 1)] = 8'($urandom_range(255));
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Offer one item, idle first if the gap says so, and step the model on acceptance.
    task automatic send_item(input byte unsigned c, input bit last);
        int gap;
        gap = (calm || hold_left > 0) ? 0 : gap_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        parse_char(c);
        if (last) begin
            if (typed_on) begin
                void'(close_line());
                expected_frames.push_back(typed_frame);
            end else begin
                expected_frames.push_back(close_line());
            end
        end
    endtask

    task automatic send_line();
        calm = ($urandom_range(3) == 0);
        foreach (line_chars[i]) send_item(line_chars[i], i == line_chars.size() - 1);
    endtask

    // Receiver: random stalls, plus one long hold-off to fill the block up.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (!i_rst_n || calm) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) < 70);
        end
    end

    // Compare every accepted frame against the oldest expectation.
    always @(posedge i_clk) begin
        t_frame w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected frame, expected none, actual tuser %b tdata %h",
                         $time, o_m_tuser, o_m_tdata);
                mismatches++;
            end else begin
                w = expected_frames.pop_front();
                check_field("frame_ok", 64'(w.ok), 64'(o_m_tuser));
                check_field("stamp_us", w.ts, o_m_tdata[TS_LSB +: TS_W]);
                check_field("identifier", 64'(w.id), 64'(o_m_tdata[ID_LSB +: ID_W]));
                check_field("byte_count", 64'(w.cnt), 64'(o_m_tdata[CNT_LSB +: COUNT_W]));
                for (int i = 0; i < NUM_BYTES; i++)
                    check_field($sformatf("data_byte%0d", i), 64'(w.bytes[i]),
                                64'(o_m_tdata[BYTES_LSB + i*BYTE_W +: BYTE_W]));
                check_field("pad", 64'd0, 64'(o_m_tdata[TDATA_W-1 -: PAD_W]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int rand_chars;
        int rand_lines;
        clear_parser();
        // Directed lines; typed rows carry their result, the rest use the model.
        add_row("a 1#FF", 1, 1, 0, 32'h1, 1, 64'hFF);
        add_row("x 7FF#001122334455667788", 1, 1, 0, 32'h7FF, 8, 64'h7766554433221100);
        add_row("(0.0) can0 0#00", 1, 1, 0, 0, 1, 0);
        add_row("a 1", 1, 0, 0, 0, 0, 0);
        add_row("(1.5) c 2#A", 1, 1, 64'd1000005, 32'h2, 1, 64'h0A);
        add_row("c 5Z#12", 1, 0, 0, 0, 0, 0);
        add_row("c 5#", 1, 0, 0, 32'h5, 0, 0);
        add_row("~", 1, 0, 0, 0, 0, 0);
        add_row("(99999999999999999999.99999999999999999999) c FFFFFFFFFF#1", 0, 0, 0, 0, 0, 0);
        add_row(" \t(12) c 123#1x23", 0, 0, 0, 0, 0, 0);
        add_row("c 5#12~34", 0, 0, 0, 0, 0, 0);
        add_row("c 5#1~", 0, 0, 0, 0, 0, 0);
        add_row("c 5#12\r\n", 0, 0, 0, 0, 0, 0);
        add_row("(3) c 1#abcdefABCDEF0", 0, 0, 0, 0, 0, 0);
        add_row("(3 c 1#ab", 0, 0, 0, 0, 0, 0);
        add_row("(+1.-2) c 0x1#ab", 0, 0, 0, 0, 0, 0);
        add_row("c 1#123456789abcdef01", 0, 0, 0, 0, 0, 0);
        add_row("c 1 #12", 0, 0, 0, 0, 0, 0);

        // Hold reset low, then release it once.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (line_rows[r]) begin
            line_chars.delete();
            for (int i = 0; i < line_rows[r].txt.len(); i++)
                line_chars.push_back(line_rows[r].txt[i] == NUL_MARK ? CH_NUL
                                                                     : line_rows[r].txt[i]);
            typed_on    = line_rows[r].typed;
            typed_frame = line_rows[r].want;
            send_line();
        end
        typed_on = 1'b0;

        rand_chars = 0;
        rand_lines = 0;
        while (rand_chars < RAND_ITEMS || rand_lines < MIN_LINES) begin
            if (rand_lines == 5) hold_req = 1'b1;
            make_line();
            send_line();
            rand_chars += line_chars.size();
            rand_lines++;
        end
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;
        calm = 1'b0;

        // Drain, then give the pipeline time to show any stray frame.
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/cftlp_pkg.sv
rtl/core/cftlp_front.sv
rtl/core/cftlp_queue.sv
rtl/core/cftlp_parse.sv
rtl/core/cftlp_emit.sv
rtl/core/can_frame_text_line_parser.sv
tb/sv/testbench.sv
